### src/sit_pkg.sv
// shared constants and types for the segment intersection test pipeline
// no dependencies; imported by every module of the block
package sit_pkg;

  // width of each coordinate field on the request port
  localparam int FIELD_W = 16;
  // default coordinate width actually used inside a field
  localparam int COORD_WIDTH_DEF = 16;

  localparam int NUM_FIELD  = 8;
  localparam int NUM_DIFF   = 12;
  localparam int NUM_ORIENT = 4;

  // coordinate order inside the field array
  localparam int IDX_AX1 = 0;
  localparam int IDX_AY1 = 1;
  localparam int IDX_AX2 = 2;
  localparam int IDX_AY2 = 3;
  localparam int IDX_BX1 = 4;
  localparam int IDX_BY1 = 5;
  localparam int IDX_BX2 = 6;
  localparam int IDX_BY2 = 7;

  // difference order: segment directions, then (r - q) pairs per orientation
  localparam int DIFF_DXA = 0;
  localparam int DIFF_DYA = 1;
  localparam int DIFF_DXB = 2;
  localparam int DIFF_DYB = 3;
  localparam int DIFF_R0  = 4;

  typedef enum logic [1:0] {
    ORIENT_COLIN = 2'd0,
    ORIENT_POS   = 2'd1,
    ORIENT_NEG   = 2'd2
  } orient_e;

endpackage

### src/sit_diff.sv
// stage one: coordinate extraction, coordinate differences, bounding box tests
// depends on sit_pkg
module sit_diff import sit_pkg::*; #(
  parameter int CoordWidth = COORD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [FIELD_W-1:0]           field_i [NUM_FIELD],
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic signed [CoordWidth:0]   diff_o [NUM_DIFF],
  output logic [NUM_ORIENT-1:0]        within_o
);

  localparam int ExtW = (CoordWidth > FIELD_W) ? CoordWidth : FIELD_W;

  logic [ExtW-1:0]                ext   [NUM_FIELD];
  logic signed [CoordWidth-1:0]   coord [NUM_FIELD];
  logic signed [CoordWidth:0]     diff_d [NUM_DIFF];
  logic signed [CoordWidth:0]     diff_q [NUM_DIFF];
  logic [NUM_ORIENT-1:0]          within_d;
  logic [NUM_ORIENT-1:0]          within_q;
  logic                           valid_q;

  // q lies between p and r, either order
  function automatic logic in_range(input logic signed [CoordWidth-1:0] q,
                                    input logic signed [CoordWidth-1:0] p,
                                    input logic signed [CoordWidth-1:0] r);
    return ((q >= p) && (q <= r)) || ((q >= r) && (q <= p));
  endfunction

  function automatic logic signed [CoordWidth:0] sub(
      input logic signed [CoordWidth-1:0] a,
      input logic signed [CoordWidth-1:0] b);
    logic signed [CoordWidth:0] ae;
    logic signed [CoordWidth:0] be;
    ae = (CoordWidth+1)'(a);
    be = (CoordWidth+1)'(b);
    return ae - be;
  endfunction

  // field bits above the coordinate width are ignored, the rest taken as signed; a narrower field is zero-extended
  always_comb begin
    for (int i = 0; i < NUM_FIELD; i++) begin
      ext[i]   = ExtW'(field_i[i]);
      coord[i] = $signed(ext[i][CoordWidth-1:0]);
    end
  end

  always_comb begin
    diff_d[DIFF_DXA]   = sub(coord[IDX_AX2], coord[IDX_AX1]);
    diff_d[DIFF_DYA]   = sub(coord[IDX_AY2], coord[IDX_AY1]);
    diff_d[DIFF_DXB]   = sub(coord[IDX_BX2], coord[IDX_BX1]);
    diff_d[DIFF_DYB]   = sub(coord[IDX_BY2], coord[IDX_BY1]);
    // segment a line against b start and b end, pivot at a end
    diff_d[DIFF_R0+0]  = sub(coord[IDX_BX1], coord[IDX_AX2]);
    diff_d[DIFF_R0+1]  = sub(coord[IDX_BY1], coord[IDX_AY2]);
    diff_d[DIFF_R0+2]  = sub(coord[IDX_BX2], coord[IDX_AX2]);
    diff_d[DIFF_R0+3]  = sub(coord[IDX_BY2], coord[IDX_AY2]);
    // segment b line against a start and a end, pivot at b end
    diff_d[DIFF_R0+4]  = sub(coord[IDX_AX1], coord[IDX_BX2]);
    diff_d[DIFF_R0+5]  = sub(coord[IDX_AY1], coord[IDX_BY2]);
    diff_d[DIFF_R0+6]  = sub(coord[IDX_AX2], coord[IDX_BX2]);
    diff_d[DIFF_R0+7]  = sub(coord[IDX_AY2], coord[IDX_BY2]);
  end

  always_comb begin
    within_d[0] = in_range(coord[IDX_BX1], coord[IDX_AX1], coord[IDX_AX2]) &&
                  in_range(coord[IDX_BY1], coord[IDX_AY1], coord[IDX_AY2]);
    within_d[1] = in_range(coord[IDX_BX2], coord[IDX_AX1], coord[IDX_AX2]) &&
                  in_range(coord[IDX_BY2], coord[IDX_AY1], coord[IDX_AY2]);
    within_d[2] = in_range(coord[IDX_AX1], coord[IDX_BX1], coord[IDX_BX2]) &&
                  in_range(coord[IDX_AY1], coord[IDX_BY1], coord[IDX_BY2]);
    within_d[3] = in_range(coord[IDX_AX2], coord[IDX_BX1], coord[IDX_BX2]) &&
                  in_range(coord[IDX_AY2], coord[IDX_BY1], coord[IDX_BY2]);
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      diff_q   <= diff_d;
      within_q <= within_d;
    end
  end

  assign valid_o  = valid_q;
  assign diff_o   = diff_q;
  assign within_o = within_q;

endmodule

### src/sit_mult.sv
// stage two: the eight cross product terms, one multiplier each
// depends on sit_pkg
module sit_mult import sit_pkg::*; #(
  parameter int CoordWidth = COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic signed [CoordWidth:0]      diff_i [NUM_DIFF],
  input  logic [NUM_ORIENT-1:0]           within_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic signed [2*CoordWidth+1:0]  left_o  [NUM_ORIENT],
  output logic signed [2*CoordWidth+1:0]  right_o [NUM_ORIENT],
  output logic [NUM_ORIENT-1:0]           within_o
);

  localparam int ProdW = 2 * CoordWidth + 2;

  logic signed [ProdW-1:0] left_d  [NUM_ORIENT];
  logic signed [ProdW-1:0] right_d [NUM_ORIENT];
  logic signed [ProdW-1:0] left_q  [NUM_ORIENT];
  logic signed [ProdW-1:0] right_q [NUM_ORIENT];
  logic [NUM_ORIENT-1:0]   within_q;
  logic                    valid_q;

  for (genvar k = 0; k < NUM_ORIENT; k++) begin : g_term
    localparam int DxI = (k < 2) ? DIFF_DXA : DIFF_DXB;
    localparam int DyI = (k < 2) ? DIFF_DYA : DIFF_DYB;
    localparam int RxI = DIFF_R0 + 2 * k;
    localparam int RyI = DIFF_R0 + 2 * k + 1;
    // left = dy * (rx - qx), right = dx * (ry - qy)
    assign left_d[k]  = ProdW'(diff_i[DyI]) * ProdW'(diff_i[RxI]);
    assign right_d[k] = ProdW'(diff_i[DxI]) * ProdW'(diff_i[RyI]);
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      left_q   <= left_d;
      right_q  <= right_d;
      within_q <= within_i;
    end
  end

  assign valid_o  = valid_q;
  assign left_o   = left_q;
  assign right_o  = right_q;
  assign within_o = within_q;

endmodule

### src/sit_orient.sv
// stage three: orientation signs from the products and the final decision
// depends on sit_pkg
module sit_orient import sit_pkg::*; #(
  parameter int CoordWidth = COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic signed [2*CoordWidth+1:0]  left_i  [NUM_ORIENT],
  input  logic signed [2*CoordWidth+1:0]  right_i [NUM_ORIENT],
  input  logic [NUM_ORIENT-1:0]           within_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic                            hit_o
);

  orient_e orient [NUM_ORIENT];
  logic    hit_d;
  logic    hit_q;
  logic    valid_q;

  always_comb begin
    for (int k = 0; k < NUM_ORIENT; k++) begin
      if (left_i[k] == right_i[k]) begin
        orient[k] = ORIENT_COLIN;
      end else if (left_i[k] > right_i[k]) begin
        orient[k] = ORIENT_POS;
      end else begin
        orient[k] = ORIENT_NEG;
      end
    end
  end

  // proper crossing, or a colinear endpoint inside the other bounding box
  always_comb begin
    hit_d = (orient[0] != orient[1]) && (orient[2] != orient[3]);
    for (int k = 0; k < NUM_ORIENT; k++) begin
      if (orient[k] == ORIENT_COLIN && within_i[k]) begin
        hit_d = 1'b1;
      end
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

### src/segment_intersection_test.sv
// top level of the segment intersection test
// depends on sit_pkg, sit_diff, sit_mult and sit_orient
//
// Takes one request per clock while in_stall_o is low: two line segments a
// and b, each given by signed start and end coordinates, and answers with one
// bit that is set when the segments cross, touch, or overlap colinearly. Only
// the low COORD_WIDTH bits of each coordinate field are used, taken as signed;
// a field narrower than COORD_WIDTH is zero-extended. The answer comes from the
// exact signs of four cross products, so there is no rounding anywhere. The
// datapath is a three-stage pipeline (differences and bounding boxes, eight
// multipliers of COORD_WIDTH+1 bits, wide compare and decision). An accepted
// request passes through the stage one, stage two and result registers in turn
// before out_valid_o shows its answer. Results come out in request order.
// When the output is stalled each stage holds its item and the stall moves
// back one stage per occupied register, so bubbles are squeezed out and
// in_stall_o rises only when all three stages are full.
module segment_intersection_test import sit_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [FIELD_W-1:0] a_start_x_i,
  input  logic signed [FIELD_W-1:0] a_start_y_i,
  input  logic signed [FIELD_W-1:0] a_end_x_i,
  input  logic signed [FIELD_W-1:0] a_end_y_i,
  input  logic signed [FIELD_W-1:0] b_start_x_i,
  input  logic signed [FIELD_W-1:0] b_start_y_i,
  input  logic signed [FIELD_W-1:0] b_end_x_i,
  input  logic signed [FIELD_W-1:0] b_end_y_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      intersects_o
);

  localparam int ProdW = 2 * COORD_WIDTH + 2;

  // request fields gathered in a fixed order for stage one
  logic [FIELD_W-1:0] field [NUM_FIELD];

  // stage one to stage two
  logic                        s1_valid;
  logic                        s1_stall;
  logic signed [COORD_WIDTH:0] s1_diff [NUM_DIFF];
  logic [NUM_ORIENT-1:0]       s1_within;

  // stage two to stage three
  logic                    s2_valid;
  logic                    s2_stall;
  logic signed [ProdW-1:0] s2_left  [NUM_ORIENT];
  logic signed [ProdW-1:0] s2_right [NUM_ORIENT];
  logic [NUM_ORIENT-1:0]   s2_within;

  assign field[IDX_AX1] = a_start_x_i;
  assign field[IDX_AY1] = a_start_y_i;
  assign field[IDX_AX2] = a_end_x_i;
  assign field[IDX_AY2] = a_end_y_i;
  assign field[IDX_BX1] = b_start_x_i;
  assign field[IDX_BY1] = b_start_y_i;
  assign field[IDX_BX2] = b_end_x_i;
  assign field[IDX_BY2] = b_end_y_i;

  // differences of coordinates and bounding box containment
  sit_diff #(
    .CoordWidth (COORD_WIDTH)
  ) u_diff (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .field_i  (field),
    .valid_o  (s1_valid),
    .stall_i  (s1_stall),
    .diff_o   (s1_diff),
    .within_o (s1_within)
  );

  // both halves of each cross product
  sit_mult #(
    .CoordWidth (COORD_WIDTH)
  ) u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .stall_o  (s1_stall),
    .diff_i   (s1_diff),
    .within_i (s1_within),
    .valid_o  (s2_valid),
    .stall_i  (s2_stall),
    .left_o   (s2_left),
    .right_o  (s2_right),
    .within_o (s2_within)
  );

  // orientation signs and the result register
  sit_orient #(
    .CoordWidth (COORD_WIDTH)
  ) u_orient (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid),
    .stall_o  (s2_stall),
    .left_i   (s2_left),
    .right_i  (s2_right),
    .within_i (s2_within),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .hit_o    (intersects_o)
  );

  // the request side can only be held off by a full pipe behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && s2_valid && out_valid_o && out_stall_i))
    else $error("request stalled while the pipeline has room");

  // an accepted request always lands in stage one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid)
    else $error("accepted request lost at stage one");

  // a result appears only after stage two held an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s2_valid))
    else $error("result appeared without an item in stage two");

endmodule
